// ===== sv/mttf_pkg.sv =====
// Shared types and constants for the multipath transit-time flow block.
`default_nettype none
package mttf_pkg;

    localparam int PATH_COUNT = 4;
    localparam int DIV_STEPS  = 64;
    localparam int CNT_W      = $clog2(DIV_STEPS);

    localparam logic [2:0] CFG_SCALE0  = 3'd0;
    localparam logic [2:0] CFG_SCALE1  = 3'd1;
    localparam logic [2:0] CFG_SCALE2  = 3'd2;
    localparam logic [2:0] CFG_SCALE3  = 3'd3;
    localparam logic [2:0] CFG_WEIGHT0 = 3'd4;
    localparam logic [2:0] CFG_WEIGHT1 = 3'd5;
    localparam logic [2:0] CFG_WEIGHT2 = 3'd6;
    localparam logic [2:0] CFG_WEIGHT3 = 3'd7;

    localparam logic signed [47:0] FLOW_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] FLOW_MIN = 48'sh8000_0000_0000;

    typedef struct packed {
        logic [1:0]  path_index;
        logic [31:0] time_upstream;
        logic [31:0] time_downstream;
        logic        last_path;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] path_velocity;
        logic               bad_time;
        logic               flow_valid;
        logic signed [47:0] flow_rate;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic mul_num;
        logic mul_den;
        logic div_step;
        logic vel;
        logic mul_w;
        logic acc;
    } t_dp_cmd;

    typedef struct packed {
        logic skip_div;
        logic out_busy;
    } t_dp_status;

endpackage
`default_nettype wire

// ===== sv/mttf_ctrl.sv =====
// Sequencer for the flow block: load, multiplies, bit-serial divide, accumulate.
`default_nettype none
module mttf_ctrl
    import mttf_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MULN = 3'd1;
    localparam logic [2:0] S_MULD = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_VEL  = 3'd4;
    localparam logic [2:0] S_MULW = 3'd5;
    localparam logic [2:0] S_ACC  = 3'd6;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                n_cnt      = '0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MULN;
                end
            end
            S_MULN: begin
                o_cmd.mul_num = 1'b1;
                n_state       = S_MULD;
            end
            S_MULD: begin
                o_cmd.mul_den = 1'b1;
                n_state       = i_status.skip_div ? S_VEL : S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_VEL;
                end
            end
            S_VEL: begin
                o_cmd.vel = 1'b1;
                n_state   = S_MULW;
            end
            S_MULW: begin
                o_cmd.mul_w = 1'b1;
                n_state     = S_ACC;
            end
            S_ACC: begin
                if (!i_status.out_busy) begin
                    o_cmd.acc = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule
`default_nettype wire

// ===== sv/mttf_dp.sv =====
// Datapath: registers, shared 32x32 multiplier, restoring divider, accumulator.
`default_nettype none
module mttf_dp
    import mttf_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [31:0] i_cfg_data,
    input  t_in_item    i_in_data,
    input  t_dp_cmd     i_cmd,
    output t_dp_status  o_status,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output t_out_item   o_out_data
);

    logic [31:0] r_scale_cfg [PATH_COUNT];
    logic [31:0] r_weight_cfg [PATH_COUNT];

    logic [31:0] r_scale, r_weight, r_tup, r_tdown, r_diff;
    logic        r_neg, r_bad, r_skip, r_last;
    logic [63:0] r_num, r_den, r_rem;
    logic [31:0] r_vmag;
    logic        r_vneg;
    logic [47:0] r_term;
    logic signed [63:0] r_acc;
    logic        r_out_valid;
    t_out_item   r_out;

    logic        path_ok;
    logic [31:0] sel_scale, sel_weight;
    logic        in_bad;
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic [64:0] rem_sh, rem_sub;
    logic [31:0] vmag;
    logic signed [63:0] term_s;
    logic signed [64:0] sum;
    logic signed [63:0] acc_new;
    logic signed [47:0] flow_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PATH_COUNT; i++) begin
                r_scale_cfg[i]  <= '0;
                r_weight_cfg[i] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SCALE0:  r_scale_cfg[0]  <= i_cfg_data;
                CFG_SCALE1:  r_scale_cfg[1]  <= i_cfg_data;
                CFG_SCALE2:  r_scale_cfg[2]  <= i_cfg_data;
                CFG_SCALE3:  r_scale_cfg[3]  <= i_cfg_data;
                CFG_WEIGHT0: r_weight_cfg[0] <= i_cfg_data;
                CFG_WEIGHT1: r_weight_cfg[1] <= i_cfg_data;
                CFG_WEIGHT2: r_weight_cfg[2] <= i_cfg_data;
                CFG_WEIGHT3: r_weight_cfg[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign path_ok    = 32'(i_in_data.path_index) < PATH_COUNT;
    assign sel_scale  = path_ok ? r_scale_cfg[i_in_data.path_index] : '0;
    assign sel_weight = path_ok ? r_weight_cfg[i_in_data.path_index] : '0;
    assign in_bad     = (i_in_data.time_upstream == '0) || (i_in_data.time_downstream == '0);

    always_comb begin
        mul_a = r_weight;
        mul_b = r_vmag;
        if (i_cmd.mul_num) begin
            mul_a = r_scale;
            mul_b = r_diff;
        end else if (i_cmd.mul_den) begin
            mul_a = r_tup;
            mul_b = r_tdown;
        end
    end
    assign prod = mul_a * mul_b;

    assign rem_sh  = {r_rem, r_num[63]};
    assign rem_sub = rem_sh - {1'b0, r_den};

    always_comb begin
        if (r_skip) begin
            vmag = '0;
        end else if (r_neg) begin
            vmag = (r_num > 64'h8000_0000) ? 32'h8000_0000 : r_num[31:0];
        end else begin
            vmag = (r_num > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : r_num[31:0];
        end
    end

    assign term_s  = r_vneg ? -{16'd0, r_term} : {16'd0, r_term};
    assign sum     = {r_acc[63], r_acc} + {term_s[63], term_s};
    assign acc_new = (sum[64] != sum[63]) ? (sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}})
                                          : sum[63:0];

    always_comb begin
        if (acc_new[63:47] == {17{1'b0}} || acc_new[63:47] == {17{1'b1}}) begin
            flow_sat = acc_new[47:0];
        end else begin
            flow_sat = acc_new[63] ? FLOW_MIN : FLOW_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_scale  <= sel_scale;
            r_weight <= sel_weight;
            r_tup    <= i_in_data.time_upstream;
            r_tdown  <= i_in_data.time_downstream;
            r_neg    <= i_in_data.time_upstream < i_in_data.time_downstream;
            r_diff   <= (i_in_data.time_upstream < i_in_data.time_downstream)
                      ? i_in_data.time_downstream - i_in_data.time_upstream
                      : i_in_data.time_upstream - i_in_data.time_downstream;
            r_bad    <= in_bad;
            r_skip   <= in_bad || (sel_scale == '0);
            r_last   <= i_in_data.last_path;
            r_rem    <= '0;
        end
        if (i_cmd.mul_num) begin
            r_num <= prod;
        end
        if (i_cmd.mul_den) begin
            r_den <= prod;
        end
        if (i_cmd.div_step) begin
            if (!rem_sub[64]) begin
                r_rem <= rem_sub[63:0];
                r_num <= {r_num[62:0], 1'b1};
            end else begin
                r_rem <= rem_sh[63:0];
                r_num <= {r_num[62:0], 1'b0};
            end
        end
        if (i_cmd.vel) begin
            r_vmag <= vmag;
            r_vneg <= r_neg && !r_skip;
        end
        if (i_cmd.mul_w) begin
            r_term <= prod[63:16];
        end
        if (i_cmd.acc) begin
            r_out.path_velocity <= r_vneg ? -$signed(r_vmag) : $signed(r_vmag);
            r_out.bad_time      <= r_bad;
            r_out.flow_valid    <= r_last;
            r_out.flow_rate     <= r_last ? flow_sat : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.acc) begin
                r_acc       <= r_last ? '0 : acc_new;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.skip_div = r_skip;
    assign o_status.out_busy = r_out_valid && i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out;

endmodule
`default_nettype wire

// ===== sv/multipath_transit_time_flow.sv =====
// Top level of the multipath transit-time flow block.
// Each transaction carries one path measurement and returns one result: the
// path velocity (signed Q16.16, saturated), a bad-time flag and, on the last
// path of a set, the accumulated flow (signed Q32.16, saturated to 48 bits).
// The result is registered after load, the two multiplies, the bit-serial
// 64-bit divider, the velocity step, the weight multiply and accumulate; the
// shared 32x32 multiplier is used three times. The next transaction is taken
// once the result is in the output register. A path with a zero time or zero
// scale skips the divider. A finished result waits in the output register
// while the next transaction is taken. Configuration writes are registered.
`default_nettype none
module multipath_transit_time_flow
    import mttf_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire [2:0]  i_cfg_index,
    input  wire [31:0] i_cfg_data,
    input  wire        i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in_data,
    output logic       o_out_valid,
    input  wire        i_out_stall,
    output t_out_item  o_out_data
);

    t_dp_cmd    cmd;
    t_dp_status status;

    mttf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    mttf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

// ===== tb/mttf_flow_checker.sv =====
`timescale 1ns / 1ps
// Flow checker: predicts each path result and set total, and compares the block's results.
module mttf_flow_checker
    import mttf_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire [2:0]  i_cfg_index,
    input  wire [31:0] i_cfg_data,
    input  wire        i_in_valid,
    input  wire        i_in_stall,
    input  t_in_item   i_in_data,
    input  wire        i_out_valid,
    input  wire        i_out_stall,
    input  t_out_item  i_out_data,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_checked,
    output int         o_flow_sets,
    output int         o_bad_times
);

    logic [31:0]        scale_q [PATH_COUNT];
    logic [31:0]        weight_q [PATH_COUNT];
    logic signed [63:0] flow_acc;
    t_out_item          results_due [$];
    int                 fails;
    int                 checked;
    int                 flow_sets;
    int                 bad_times;

    function automatic logic signed [31:0] transit_speed(input logic [31:0] scale,
                                                         input logic [31:0] up,
                                                         input logic [31:0] down);
        logic        neg;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] quo;
        neg = up < down;
        num = 64'(scale) * 64'(neg ? down - up : up - down);
        den = 64'(up) * 64'(down);
        quo = num / den;
        if (neg) begin
            return (quo > 64'h8000_0000) ? 32'h8000_0000 : 32'(-quo);
        end
        return (quo > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(quo);
    endfunction

    function automatic logic signed [63:0] weighted_flow(input logic [31:0] weight,
                                                         input logic signed [31:0] speed);
        logic signed [63:0] wide;
        logic [63:0]        mag;
        logic [63:0]        prod;
        wide = speed;
        mag  = wide[63] ? -wide : wide;
        prod = (64'(weight) * mag) >> 16;
        return wide[63] ? -prod : prod;
    endfunction

    always @(posedge i_clk) begin
        t_out_item          want;
        t_out_item          got;
        logic [31:0]        sc;
        logic [31:0]        wt;
        logic signed [64:0] sum65;
        if (!i_rst_n) begin
            foreach (scale_q[p]) begin
                scale_q[p]  = '0;
                weight_q[p] = '0;
            end
            flow_acc = '0;
            results_due.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index <= CFG_SCALE3) begin
                    scale_q[2'(i_cfg_index - CFG_SCALE0)] = i_cfg_data;
                end else begin
                    weight_q[2'(i_cfg_index - CFG_WEIGHT0)] = i_cfg_data;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                sc = '0;
                wt = '0;
                if (i_in_data.path_index < PATH_COUNT) begin
                    sc = scale_q[i_in_data.path_index];
                    wt = weight_q[i_in_data.path_index];
                end
                want.bad_time      = (i_in_data.time_upstream == '0) ||
                                     (i_in_data.time_downstream == '0);
                want.path_velocity = '0;
                if (!want.bad_time && sc != '0) begin
                    want.path_velocity = transit_speed(sc, i_in_data.time_upstream,
                                                       i_in_data.time_downstream);
                end
                sum65 = 65'(flow_acc) + 65'(weighted_flow(wt, want.path_velocity));
                if (sum65[64] != sum65[63]) begin
                    flow_acc = sum65[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
                end else begin
                    flow_acc = sum65[63:0];
                end
                want.flow_valid = i_in_data.last_path;
                want.flow_rate  = '0;
                if (i_in_data.last_path) begin
                    if (flow_acc > 64'(FLOW_MAX)) begin
                        want.flow_rate = FLOW_MAX;
                    end else if (flow_acc < 64'(FLOW_MIN)) begin
                        want.flow_rate = FLOW_MIN;
                    end else begin
                        want.flow_rate = flow_acc[47:0];
                    end
                    flow_acc = '0;
                    flow_sets++;
                end
                if (want.bad_time) begin
                    bad_times++;
                end
                results_due.push_back(want);
            end
            if (i_out_valid && !i_out_stall) begin
                got = i_out_data;
                if (results_due.size() == 0) begin
                    fails++;
                    $display("%0t unexpected result: vel %0d bad %0b valid %0b flow %0d",
                             $time, got.path_velocity, got.bad_time, got.flow_valid,
                             got.flow_rate);
                end else begin
                    want = results_due.pop_front();
                    checked++;
                    if (got !== want) begin
                        fails++;
                        $display({"%0t result %0d mismatch: ",
                                  "expected vel %0d bad %0b valid %0b flow %0d"},
                                 $time, checked, want.path_velocity, want.bad_time,
                                 want.flow_valid, want.flow_rate);
                        $display({"%0t result %0d mismatch: ",
                                  "actual   vel %0d bad %0b valid %0b flow %0d"},
                                 $time, checked, got.path_velocity, got.bad_time,
                                 got.flow_valid, got.flow_rate);
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= results_due.size();
        o_checked    <= checked;
        o_flow_sets  <= flow_sets;
        o_bad_times  <= bad_times;
    end

endmodule

// ===== tb/tb_multipath_transit_time_flow.sv =====
`timescale 1ns / 1ps
// Testbench top: drives measurements, register writes and output stalls, and gives the verdict.
module tb_multipath_transit_time_flow;
    import mttf_pkg::*;

    localparam int IDLE_LIMIT   = 3000;
    localparam int HOLD_CYCLES  = 500;
    localparam int DRAIN_CYCLES = 80;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 140;
    localparam int REG_COUNT    = 8;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    t_in_item    in_data;
    logic        out_valid;
    logic        out_stall;
    t_out_item   out_data;

    bit          quiet;
    bit          hold_request;
    int          idle_cycles = 0;
    int          fail_count;
    int          pending;
    int          checked;
    int          flow_sets;
    int          bad_times;
    logic [31:0] reg_value [REG_COUNT];

    multipath_transit_time_flow DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    mttf_flow_checker flow_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_flow_sets  (flow_sets),
        .o_bad_times  (bad_times)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("multipath_transit_time_flow verification failed");
            $finish;
        end
    end

    initial begin
        int held;
        forever begin
            if (hold_request) begin
                out_stall <= 1'b1;
                for (held = 0; held < HOLD_CYCLES; held++) begin
                    @(posedge i_clk);
                end
                hold_request = 1'b0;
            end else if (quiet || $urandom_range(0, 5) != 0) begin
                out_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    end

    task automatic send_path(input logic [1:0] path, input logic [31:0] up,
                             input logic [31:0] down, input logic last);
        in_data.path_index      <= path;
        in_data.time_upstream   <= up;
        in_data.time_downstream <= down;
        in_data.last_path       <= last;
        in_valid                <= 1'b1;
        do @(posedge i_clk); while (in_stall);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic program_regs();
        for (int r = 0; r < REG_COUNT; r++) begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_SCALE0 + 3'(r);
            cfg_data  <= reg_value[r];
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    function automatic logic [31:0] draw_time(input logic [31:0] base);
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            return '0;
        end
        if (pick == 1) begin
            return '1;
        end
        if (pick <= 3) begin
            return $urandom;
        end
        if (pick <= 5) begin
            return $urandom_range(1, 64);
        end
        return base + $urandom_range(0, 4095) - 2048;
    endfunction

    initial begin
        int          set_len;
        int          first_path;
        int          phase_items;
        logic [31:0] base;
        i_rst_n   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        in_data   = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // registers still at reset: every path disabled
        send_path(2'd0, 32'd100, 32'd50, 1'b0);
        send_path(2'd3, 32'd9, 32'd10, 1'b1);
        wait_idle();

        reg_value = '{32'hFFFF_FFFF, 32'h0, 32'h0064_0000, 32'h1,
                      32'hFFFF_FFFF, 32'h0001_0000, 32'h0002_8000, 32'h0};
        program_regs();
        send_path(2'd0, 32'd1, 32'd2, 1'b0);
        send_path(2'd0, 32'd2, 32'd1, 1'b0);
        send_path(2'd0, 32'd1, 32'hFFFF_FFFF, 1'b0);
        send_path(2'd0, 32'hFFFF_FFFF, 32'd1, 1'b1);
        send_path(2'd0, 32'd2, 32'd1, 1'b0);
        send_path(2'd0, 32'd2, 32'd1, 1'b1);
        send_path(2'd0, 32'd1, 32'hFFFF_FFFF, 1'b0);
        send_path(2'd0, 32'd1, 32'hFFFF_FFFF, 1'b1);
        send_path(2'd2, 32'd0, 32'd5, 1'b0);
        send_path(2'd2, 32'd7, 32'd0, 1'b0);
        send_path(2'd2, 32'd0, 32'd0, 1'b1);
        send_path(2'd2, 32'd1000, 32'd1000, 1'b0);
        send_path(2'd1, 32'd3000, 32'd1000, 1'b1);
        send_path(2'd2, 32'd1000, 32'd999, 1'b0);
        send_path(2'd3, 32'd1, 32'd2, 1'b0);
        send_path(2'd2, 32'd999, 32'd1000, 1'b1);
        send_path(2'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_path(2'd1, 32'd0, 32'hFFFF_FFFF, 1'b1);
        send_path(2'd3, 32'd2, 32'd1, 1'b1);
        wait_idle();

        for (int ph = 0; ph < PHASES; ph++) begin
            for (int r = 0; r < REG_COUNT; r++) begin
                case (ph)
                    0: reg_value[r] = '1;
                    1: reg_value[r] = $urandom_range(0, 1) ? $urandom : 32'h0;
                    3: reg_value[r] = (r < PATH_COUNT) ? $urandom_range(1, 32'hFFFF)
                                                        : $urandom_range(0, 32'h00FF_FFFF);
                    default: reg_value[r] = $urandom;
                endcase
            end
            program_regs();
            quiet = (ph == PHASES - 1);
            if (ph == 2) begin
                hold_request = 1'b1;
            end
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                base = ($urandom_range(0, 3) == 0) ? $urandom_range(4096, 32'hFFFF_E000)
                                                   : $urandom_range(4096, 200000);
                if ($urandom_range(0, 6) != 0) begin
                    set_len    = $urandom_range(1, PATH_COUNT);
                    first_path = $urandom_range(0, PATH_COUNT - set_len);
                    for (int k = 0; k < set_len; k++) begin
                        send_path(2'(first_path + k), draw_time(base), draw_time(base),
                                  k == set_len - 1);
                    end
                    phase_items += set_len;
                end else begin
                    send_path(2'($urandom), draw_time(base), $urandom, 1'($urandom));
                    phase_items++;
                end
            end
            wait_idle();
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d path results over %0d register settings: %0d flow sets, %0d zero-time measurements.",
                 checked, PHASES + 2, flow_sets, bad_times);
        $display("Run included saturation at both limits, disabled paths, random stalls and a long output hold-off.");
        if (fail_count == 0 && pending == 0) begin
            $display("multipath_transit_time_flow verification clean");
        end else begin
            $display("multipath_transit_time_flow verification failed");
        end
        $finish;
    end

endmodule
